// ===== hw/rtl/jqsp_pkg.sv =====
// ----------------------------------------------------------------------------
// jqsp_pkg: shared types and constants of the print job queue
// Request codes, status codes, controller/datapath command and status types.
// ----------------------------------------------------------------------------
package jqsp_pkg;

   localparam int DefQueueDepth = 16;
   localparam int DefNameBytes  = 30;
   localparam int DefOwnerBytes = 20;

   localparam logic [2:0] REQ_PUSH  = 3'd0;
   localparam logic [2:0] REQ_POP   = 3'd1;
   localparam logic [2:0] REQ_FIND  = 3'd2;
   localparam logic [2:0] REQ_PURGE = 3'd3;
   localparam logic [2:0] REQ_CLEAR = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   // Job record as stored in one slot: id, pages, name 30 B, owner 20 B
   localparam int JobWidth = 32 + 31 + 240 + 160;

   typedef struct packed {
      logic [31:0]  id;
      logic [30:0]  pages;
      logic [239:0] name;
      logic [159:0] owner;
   } job_type;

   // Controller to datapath commands
   typedef struct packed {
      logic latch_req;   // capture the request item
      logic push;        // write request job at tail
      logic pop;         // drop head
      logic clear;       // empty the queue
      logic walk_start;  // reset walk counters, issue first read
      logic walk_step;   // consume read data, advance
      logic purge_end;   // commit kept count
      logic emit;        // load result register
      logic [1:0] status;
      logic use_job;     // result carries the read job
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [2:0] req;
      logic empty;
      logic full;
      logic walk_done;   // all entries visited
      logic id_hit;      // read entry matches id key
   } sts_type;

   // Owner compare: bytes equal up to and including first zero byte
   function automatic logic owner_match(input logic [159:0] a, input logic [159:0] b,
                                        input int nbytes);
      logic res;
      logic stop;
      res  = 1'b1;
      stop = 1'b0;
      for (int i = 0; i < 20; i++) begin
         if (!stop && i < nbytes) begin
            if (a[i*8 +: 8] != b[i*8 +: 8]) begin
               res  = 1'b0;
               stop = 1'b1;
            end else if (a[i*8 +: 8] == 8'd0) begin
               stop = 1'b1;
            end
         end
      end
      return res;
   endfunction

   function automatic logic [255:0] byte_keep(input int nbytes);
      logic [255:0] m;
      for (int i = 0; i < 32; i++) m[i*8 +: 8] = (i < nbytes) ? 8'hff : 8'h00;
      return m;
   endfunction

endpackage

// ===== hw/rtl/jqsp_if.sv =====
// ----------------------------------------------------------------------------
// jqsp_req_if / jqsp_rsp_if: valid/ready channels of the job queue
// Request channel carries one operation, response channel one result.
// ----------------------------------------------------------------------------
interface jqsp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [31:0] job_id;
   logic [30:0] page_count;
   logic [63:0] name_word0;
   logic [63:0] name_word1;
   logic [63:0] name_word2;
   logic [47:0] name_word3;
   logic [63:0] owner_word0;
   logic [63:0] owner_word1;
   logic [31:0] owner_word2;
   modport source (output valid, req_type, job_id, page_count, name_word0, name_word1,
                   name_word2, name_word3, owner_word0, owner_word1, owner_word2,
                   input ready);
   modport sink (input valid, req_type, job_id, page_count, name_word0, name_word1,
                 name_word2, name_word3, owner_word0, owner_word1, owner_word2,
                 output ready);
endinterface

interface jqsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] out_id;
   logic [30:0] out_pages;
   logic [63:0] out_name0;
   logic [63:0] out_name1;
   logic [63:0] out_name2;
   logic [47:0] out_name3;
   logic [63:0] out_owner0;
   logic [63:0] out_owner1;
   logic [31:0] out_owner2;
   logic [4:0]  pending_count;
   logic [4:0]  purged_count;
   modport source (output valid, status, out_id, out_pages, out_name0, out_name1, out_name2,
                   out_name3, out_owner0, out_owner1, out_owner2, pending_count,
                   purged_count, input ready);
   modport sink (input valid, status, out_id, out_pages, out_name0, out_name1, out_name2,
                 out_name3, out_owner0, out_owner1, out_owner2, pending_count,
                 purged_count, output ready);
endinterface

// ===== hw/rtl/jqsp_ram.sv =====
// ----------------------------------------------------------------------------
// jqsp_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module jqsp_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write then registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/jqsp_datapath.sv =====
// ----------------------------------------------------------------------------
// jqsp_datapath: ring store, pointers and walk logic of the job queue
// Holds the request, the job RAM, head/tail/occupancy and the result register.
// ----------------------------------------------------------------------------
module jqsp_datapath
   import jqsp_pkg::*;
#(
   parameter int QueueDepth = DefQueueDepth,
   parameter int NameBytes  = DefNameBytes,
   parameter int OwnerBytes = DefOwnerBytes
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   jqsp_req_if.sink    req,
   output logic [1:0]  res_status,
   output job_type     res_job,
   output logic [4:0]  res_pending,
   output logic [4:0]  res_purged
);

   localparam int AW = $clog2(QueueDepth);
   localparam int CW = $clog2(QueueDepth + 1);
   localparam logic [CW-1:0] DepthC = CW'(QueueDepth);
   localparam logic [255:0] NameKeep  = byte_keep(NameBytes);
   localparam logic [255:0] OwnerKeep = byte_keep(OwnerBytes);

   // Latched request
   logic [2:0]   req_ff;
   logic [31:0]  key_ff;
   job_type      rjob_ff;

   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] rd_i_ff, rd_i_in;   // entries read so far
   logic [CW-1:0] ch_i_ff, ch_i_in;   // entries checked so far
   logic [CW-1:0] kept_ff, kept_in;
   logic [CW-1:0] purged_ff, purged_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   job_type       wr_data, rd_job;
   logic          owner_hit;

   function automatic logic [AW-1:0] ring(input logic [AW-1:0] base, input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(off);
      if (s >= (CW+1)'(QueueDepth)) s = s - (CW+1)'(QueueDepth);
      return s[AW-1:0];
   endfunction

   jqsp_ram #(.Width(JobWidth), .Depth(QueueDepth)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_job)
   );

   assign owner_hit = owner_match(rd_job.owner, rjob_ff.owner, OwnerBytes);

   // Status to controller
   always_comb begin
      sts.req       = req_ff;
      sts.empty     = (occ_ff == '0);
      sts.full      = (occ_ff >= DepthC);
      sts.walk_done = (ch_i_ff >= occ_ff);
      sts.id_hit    = (rd_job.id == key_ff);
   end

   // Ram write: push at tail, or purge compaction
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = tail_ff;
      wr_data = rjob_ff;
      if (cmd.push) begin
         wr_en = 1'b1;
      end else if (cmd.walk_step && req_ff == REQ_PURGE && !owner_hit) begin
         wr_en   = (kept_ff != ch_i_ff);
         wr_addr = ring(head_ff, kept_ff);
         wr_data = rd_job;
      end
   end

   // Read pointer: pipelined walk, one entry per cycle
   always_comb begin
      rd_addr = ring(head_ff, rd_i_ff);
      if (cmd.walk_start) rd_addr = head_ff;
   end

   // Pointer and counter updates
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      rd_i_in   = rd_i_ff;
      ch_i_in   = ch_i_ff;
      kept_in   = kept_ff;
      purged_in = purged_ff;
      if (cmd.latch_req) purged_in = '0;
      if (cmd.push) begin
         tail_in = ring(tail_ff, CW'(1));
         occ_in  = occ_ff + CW'(1);
      end
      if (cmd.pop) begin
         head_in = ring(head_ff, CW'(1));
         occ_in  = occ_ff - CW'(1);
      end
      if (cmd.clear) begin
         purged_in = occ_ff;
         occ_in    = '0;
         head_in   = '0;
         tail_in   = '0;
      end
      if (cmd.walk_start) begin
         rd_i_in = CW'(1);
         ch_i_in = '0;
         kept_in = '0;
      end
      if (cmd.walk_step) begin
         rd_i_in = rd_i_ff + CW'(1);
         ch_i_in = ch_i_ff + CW'(1);
         if (req_ff == REQ_PURGE) begin
            if (owner_hit) purged_in = purged_ff + CW'(1);
            else           kept_in   = kept_ff + CW'(1);
         end
      end
      if (cmd.purge_end) begin
         occ_in  = kept_ff;
         tail_in = ring(head_ff, kept_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         occ_ff    <= '0;
         rd_i_ff   <= '0;
         ch_i_ff   <= '0;
         kept_ff   <= '0;
         purged_ff <= '0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         occ_ff    <= occ_in;
         rd_i_ff   <= rd_i_in;
         ch_i_ff   <= ch_i_in;
         kept_ff   <= kept_in;
         purged_ff <= purged_in;
      end
   end

   // Capture request payload, masked to the configured string lengths
   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff <= REQ_PUSH;
      end else if (cmd.latch_req) begin
         req_ff <= req.req_type;
      end
      if (cmd.latch_req) begin
         key_ff        <= req.job_id;
         rjob_ff.id    <= req.job_id;
         rjob_ff.pages <= req.page_count;
         rjob_ff.name  <= {req.name_word3, req.name_word2, req.name_word1, req.name_word0}
                          & NameKeep[239:0];
         rjob_ff.owner <= {req.owner_word2, req.owner_word1, req.owner_word0}
                          & OwnerKeep[159:0];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         res_status  <= cmd.status;
         res_job     <= cmd.use_job ? rd_job : '0;
         res_pending <= 5'(occ_in);
         res_purged  <= 5'(purged_in);
      end
   end

endmodule

// ===== hw/rtl/jqsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// jqsp_ctrl: sequencer of the job queue
// Accepts an item, steps the datapath through the operation, hands the result.
// ----------------------------------------------------------------------------
module jqsp_ctrl
   import jqsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {S_IDLE, S_DECODE, S_WALK, S_HOLD} state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      cmd          = '0;
      if (out_valid_ff && out_ready) out_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid && in_ready) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_HOLD;
            cmd.emit = 1'b1;
            case (sts.req)
               REQ_PUSH: begin
                  if (sts.full) cmd.status = ST_FULL;
                  else          cmd.push   = 1'b1;
               end
               REQ_POP, REQ_FIND, REQ_PURGE, REQ_CLEAR: begin
                  if (sts.empty) begin
                     cmd.status = ST_EMPTY;
                  end else if (sts.req == REQ_CLEAR) begin
                     cmd.clear = 1'b1;
                  end else begin
                     cmd.emit       = 1'b0;
                     cmd.walk_start = 1'b1;
                     state_in       = S_WALK;
                  end
               end
               default: ;
            endcase
         end
         S_WALK: begin
            // read data of the current entry is valid here
            if (sts.req == REQ_POP) begin
               cmd.emit    = 1'b1;
               cmd.use_job = 1'b1;
               cmd.pop     = 1'b1;
               state_in    = S_HOLD;
            end else if (sts.walk_done) begin
               cmd.emit = 1'b1;
               if (sts.req == REQ_FIND) cmd.status = ST_NOTFOUND;
               else                     cmd.purge_end = 1'b1;
               state_in = S_HOLD;
            end else if (sts.req == REQ_FIND && sts.id_hit) begin
               cmd.emit    = 1'b1;
               cmd.use_job = 1'b1;
               state_in    = S_HOLD;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_HOLD: begin
            if (!out_valid_ff) begin
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Take a new item only when idle and the result register is free or being taken
   assign in_ready  = (state_ff == S_IDLE) && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;

   // Accept only when idle
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> state_ff == S_DECODE) else $error("accept outside idle");
   // A result stays offered until taken
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("result dropped");
   // Push and walk never start together
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.walk_start)) else $error("conflicting commands");

endmodule

// ===== hw/rtl/job_queue_search_purge.sv =====
// ----------------------------------------------------------------------------
// job_queue_search_purge: bounded FIFO of print jobs with find and purge
// Top level joining sequencer, datapath and ring store.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one operation per item: push, pop, find by id,
//   purge by owner or clear. rsp channel returns exactly one result item
//   per request, with status, the popped/found job, pending and purged
//   counts.
//   Sequence: an accepted item is first decoded. Push, clear, unknown
//   requests and empty/full cases then load the result; pop reads the
//   head. Find and purge walk the store one entry per cycle through the
//   registered RAM read port, a find up to the first id hit or over all
//   pending jobs, a purge over all pending jobs. One item is in work at a time;
//   req_ready is high only when the block is idle and the result register
//   is empty or being taken in that cycle.
//   The result sits in an output register; if the receiver stalls, the next
//   item is not accepted until that register drains.
//   Reset empties the queue (head, tail, count to zero); stored jobs are
//   not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module job_queue_search_purge
   import jqsp_pkg::*;
#(
   parameter int QueueDepth = DefQueueDepth,
   parameter int NameBytes  = DefNameBytes,
   parameter int OwnerBytes = DefOwnerBytes
) (
   input logic        clock,
   input logic        reset,
   jqsp_req_if.sink   req,
   jqsp_rsp_if.source rsp
);

   cmd_type    cmd;
   sts_type    sts;
   logic [1:0] res_status;
   job_type    res_job;
   logic [4:0] res_pending, res_purged;

   jqsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   jqsp_datapath #(
      .QueueDepth (QueueDepth),
      .NameBytes  (NameBytes),
      .OwnerBytes (OwnerBytes)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req         (req),
      .res_status  (res_status),
      .res_job     (res_job),
      .res_pending (res_pending),
      .res_purged  (res_purged)
   );

   // Drive the result channel
   assign rsp.status        = res_status;
   assign rsp.out_id        = res_job.id;
   assign rsp.out_pages     = res_job.pages;
   assign rsp.out_name0     = res_job.name[63:0];
   assign rsp.out_name1     = res_job.name[127:64];
   assign rsp.out_name2     = res_job.name[191:128];
   assign rsp.out_name3     = res_job.name[239:192];
   assign rsp.out_owner0    = res_job.owner[63:0];
   assign rsp.out_owner1    = res_job.owner[127:64];
   assign rsp.out_owner2    = res_job.owner[159:128];
   assign rsp.pending_count = res_pending;
   assign rsp.purged_count  = res_purged;

endmodule
